// ===== src/mlcb_pkg.sv =====
// ============================================================================
// Mouse-look camera basis package
// Shared types, constants and the CORDIC arctangent table.
// ============================================================================
package mlcb_pkg;

    localparam int ANG_W      = 25;
    localparam int PITCH_W    = 24;
    localparam int CUR_W      = 24;
    localparam int SENS_W     = 16;
    localparam int VEC_W      = 16;
    localparam int CW         = 34;
    localparam int ZW         = 35;

    localparam logic signed [ANG_W-1:0] YAW_RESET = -25'sd5898240;
    localparam logic signed [27:0] YAW_HALF  = 28'sd11796480;
    localparam logic signed [27:0] PITCH_LIM = 28'sd5832704;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [ZW-1:0] DEG90  = 35'sd1509949440;
    localparam logic signed [ZW-1:0] DEG180 = 35'sd3019898880;

    localparam logic [0:0] ADDR_SENS = 1'b0;

    typedef struct packed {
        logic load;
        logic scale;
        logic update;
        logic cordic_start;
        logic cordic_sel;
        logic mul_step;
        logic [1:0] mul_idx;
        logic latch_out;
    } mlcb_cmd_t;

    typedef struct packed {
        logic cordic_done;
    } mlcb_sts_t;

    function automatic logic [31:0] atan_deg24(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0: r = 32'd754974720;  5'd1: r = 32'd445687602;
                5'd2: r = 32'd235489088;  5'd3: r = 32'd119537938;
                5'd4: r = 32'd60000934;   5'd5: r = 32'd30029717;
                5'd6: r = 32'd15018523;   5'd7: r = 32'd7509720;
                5'd8: r = 32'd3754917;    5'd9: r = 32'd1877466;
                5'd10: r = 32'd938734;    5'd11: r = 32'd469367;
                5'd12: r = 32'd234684;    5'd13: r = 32'd117342;
                5'd14: r = 32'd58671;     5'd15: r = 32'd29335;
                5'd16: r = 32'd14668;     5'd17: r = 32'd7334;
                5'd18: r = 32'd3667;      5'd19: r = 32'd1833;
                5'd20: r = 32'd917;       5'd21: r = 32'd458;
                5'd22: r = 32'd229;       5'd23: r = 32'd115;
                5'd24: r = 32'd57;        5'd25: r = 32'd29;
                5'd26: r = 32'd14;        5'd27: r = 32'd7;
                5'd28: r = 32'd4;         5'd29: r = 32'd2;
                5'd30: r = 32'd1;         default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== src/mlcb_cordic.sv =====
// ============================================================================
// Mouse-look CORDIC unit
// Iterative rotation-mode sine and cosine of an angle in degrees, one step a cycle.
// ============================================================================
module mlcb_cordic #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [mlcb_pkg::ANG_W-1:0] angle,
    output logic                          done,
    output logic signed [mlcb_pkg::CW-1:0] sin_out,
    output logic signed [mlcb_pkg::CW-1:0] cos_out
);
    import mlcb_pkg::*;

    localparam int ITER = (TRIG_ITERATIONS > 32) ? 32 : TRIG_ITERATIONS;

    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next, z0;
    logic [5:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, flip_reg, flip_next, done_reg, done_next;
    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] at;

    always_comb begin
        z0 = ZW'(angle) <<< 8;
        dx = x_reg >>> cnt_reg[4:0];
        dy = y_reg >>> cnt_reg[4:0];
        at = $signed({3'b000, atan_deg24(cnt_reg[4:0])});
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        flip_next = flip_reg;
        done_next = 1'b0;
        if (start) begin
            x_next = CORDIC_GAIN;
            y_next = '0;
            cnt_next = '0;
            busy_next = 1'b1;
            flip_next = 1'b0;
            z_next = z0;
            if (z0 > DEG90) begin
                z_next = z0 - DEG180;
                flip_next = 1'b1;
            end else if (z0 < -DEG90) begin
                z_next = z0 + DEG180;
                flip_next = 1'b1;
            end
        end else if (busy_reg) begin
            if (cnt_reg == 6'(ITER)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (flip_reg) begin
                    x_next = -x_reg;
                    y_next = -y_reg;
                end
            end else begin
                if (!z_reg[ZW-1]) begin
                    x_next = x_reg - dy;
                    y_next = y_reg + dx;
                    z_next = z_reg - at;
                end else begin
                    x_next = x_reg + dy;
                    y_next = y_reg - dx;
                    z_next = z_reg + at;
                end
                cnt_next = cnt_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        cnt_reg <= cnt_next;
        flip_reg <= flip_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign sin_out = y_reg;
    assign cos_out = x_reg;

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg)) else $error("cordic done without busy");
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("cordic done while busy");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg <= 6'(ITER)) else $error("cordic count overrun");

endmodule

// ===== src/mlcb_datapath.sv =====
// ============================================================================
// Mouse-look datapath
// Angle accumulation, CORDIC results, basis products and output registers.
// ============================================================================
module mlcb_datapath #(
    parameter int VECTOR_FRAC_BITS = 15,
    parameter int TRIG_ITERATIONS  = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mlcb_pkg::mlcb_cmd_t                 cmd,
    output mlcb_pkg::mlcb_sts_t                 sts,
    input  logic [mlcb_pkg::SENS_W-1:0]         sens,
    input  logic signed [mlcb_pkg::CUR_W-1:0]   cursor_x,
    input  logic signed [mlcb_pkg::CUR_W-1:0]   cursor_y,
    output logic signed [mlcb_pkg::VEC_W-1:0]   forward_x,
    output logic signed [mlcb_pkg::VEC_W-1:0]   forward_y,
    output logic signed [mlcb_pkg::VEC_W-1:0]   forward_z,
    output logic signed [mlcb_pkg::VEC_W-1:0]   right_x,
    output logic signed [mlcb_pkg::VEC_W-1:0]   right_z,
    output logic signed [mlcb_pkg::VEC_W-1:0]   up_x,
    output logic signed [mlcb_pkg::VEC_W-1:0]   up_y,
    output logic signed [mlcb_pkg::VEC_W-1:0]   up_z,
    output logic signed [mlcb_pkg::ANG_W-1:0]   yaw_angle,
    output logic signed [mlcb_pkg::PITCH_W-1:0] pitch_angle
);
    import mlcb_pkg::*;

    localparam int SH = 30 - VECTOR_FRAC_BITS;

    logic signed [CUR_W-1:0] cx_reg, cy_reg, px_reg, py_reg;
    logic first_reg;
    logic signed [ANG_W-1:0] yaw_reg, yaw_next, yaw_out_reg;
    logic signed [PITCH_W-1:0] pitch_reg, pitch_next, pitch_out_reg;
    logic signed [CW-1:0] sy_reg, cyw_reg, sp_reg, cp_reg;
    logic signed [CW-1:0] p_reg [4];
    logic signed [CUR_W-1:0] bx, by;
    logic signed [CUR_W:0] dxr, dyr;
    logic signed [CUR_W+SENS_W+1:0] mx, my;
    logic signed [CUR_W+SENS_W-6:0] sx, sy8;
    logic signed [CUR_W+SENS_W-6:0] dyaw_reg, dpit_reg;
    logic signed [CUR_W+SENS_W-6:0] tyaw, tpit;
    logic signed [18:0] ya;
    logic signed [15:0] yc;
    logic [16:0] yo;
    logic [32:0] yq_prod;
    logic [10:0] yq;
    logic [5:0] yr;
    logic signed [25:0] yw;
    logic cdone;
    logic signed [CW-1:0] csin, ccos, ma, mb;
    logic signed [2*CW-1:0] prod;
    logic signed [VEC_W-1:0] v_fx, v_fy, v_fz, v_rx, v_rz, v_ux, v_uy, v_uz;
    logic signed [VEC_W-1:0] fx_reg, fy_reg, fz_reg, rx_reg, rz_reg, ux_reg, uy_reg, uz_reg;

    function automatic logic signed [VEC_W-1:0] vec_out(input logic signed [CW:0] v);
        logic signed [CW:0] r;
        begin
            r = (v + (CW+1)'(1 << (SH - 1))) >>> SH;
            if (r > 32767) return 16'sh7fff;
            if (r < -32768) return -16'sh8000;
            return r[VEC_W-1:0];
        end
    endfunction

    function automatic logic signed [CW-1:0] rnd30(input logic signed [2*CW-1:0] v);
        logic signed [2*CW-1:0] r;
        begin
            r = (v + (2*CW)'(1 << 29)) >>> 30;
            return r[CW-1:0];
        end
    endfunction

    mlcb_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.cordic_start),
        .angle   (cmd.cordic_sel ? ANG_W'(pitch_reg) : yaw_reg),
        .done    (cdone),
        .sin_out (csin),
        .cos_out (ccos)
    );

    // Yaw wraps modulo 360 degrees. The fraction bits pass through, and the
    // whole degrees are reduced modulo 45 after a shift by three.
    always_comb begin
        bx = first_reg ? cx_reg : px_reg;
        by = first_reg ? cy_reg : py_reg;
        dxr = (CUR_W+1)'(cx_reg) - (CUR_W+1)'(bx);
        dyr = (CUR_W+1)'(by) - (CUR_W+1)'(cy_reg);
        mx = (CUR_W+SENS_W+2)'(dxr) * $signed({2'b00, sens});
        my = (CUR_W+SENS_W+2)'(dyr) * $signed({2'b00, sens});
        sx = (CUR_W+SENS_W-5)'((mx + 42'sd128) >>> 8);
        sy8 = (CUR_W+SENS_W-5)'((my + 42'sd128) >>> 8);
        tyaw = (CUR_W+SENS_W-5)'(yaw_reg) + dyaw_reg + (CUR_W+SENS_W-5)'(YAW_HALF);
        ya = 19'(tyaw >>> 16);
        yc = 16'(ya >>> 3);
        yo = 17'(yc) + 17'd32805;
        yq_prod = 33'(yo) * 33'd93207;
        yq = yq_prod[32:22];
        yr = 6'(yo - 17'(yq) * 17'd45);
        yw = $signed({1'b0, yr, ya[2:0], tyaw[15:0]}) - 26'(YAW_HALF);
        yaw_next = yw[ANG_W-1:0];
        tpit = (CUR_W+SENS_W-5)'(pitch_reg) + dpit_reg;
        if (tpit > (CUR_W+SENS_W-5)'(PITCH_LIM)) tpit = (CUR_W+SENS_W-5)'(PITCH_LIM);
        if (tpit < -(CUR_W+SENS_W-5)'(PITCH_LIM)) tpit = -(CUR_W+SENS_W-5)'(PITCH_LIM);
        pitch_next = PITCH_W'(tpit);
        case (cmd.mul_idx)
            2'd0: begin ma = cyw_reg; mb = cp_reg; end
            2'd1: begin ma = sy_reg;  mb = cp_reg; end
            2'd2: begin ma = cyw_reg; mb = sp_reg; end
            default: begin ma = sy_reg; mb = sp_reg; end
        endcase
        prod = (2*CW)'(ma) * (2*CW)'(mb);
        v_fx = vec_out((CW+1)'(p_reg[0]));
        v_fy = vec_out((CW+1)'(sp_reg));
        v_fz = vec_out((CW+1)'(p_reg[1]));
        v_rx = vec_out(-(CW+1)'(sy_reg));
        v_rz = vec_out((CW+1)'(cyw_reg));
        v_ux = vec_out(-(CW+1)'(p_reg[2]));
        v_uy = vec_out((CW+1)'(cp_reg));
        v_uz = vec_out(-(CW+1)'(p_reg[3]));
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cx_reg <= cursor_x;
            cy_reg <= cursor_y;
        end
        if (cmd.scale) begin
            dyaw_reg <= sx;
            dpit_reg <= sy8;
        end
        if (cdone) begin
            if (cmd.cordic_sel) begin
                sp_reg <= csin;
                cp_reg <= ccos;
            end else begin
                sy_reg <= csin;
                cyw_reg <= ccos;
            end
        end
        if (cmd.mul_step) p_reg[cmd.mul_idx] <= rnd30(prod);
        if (cmd.latch_out) begin
            fx_reg <= v_fx; fy_reg <= v_fy; fz_reg <= v_fz;
            rx_reg <= v_rx; rz_reg <= v_rz;
            ux_reg <= v_ux; uy_reg <= v_uy; uz_reg <= v_uz;
            yaw_out_reg <= yaw_reg;
            pitch_out_reg <= pitch_reg;
        end
        if (!aresetn) begin
            yaw_reg <= YAW_RESET;
            pitch_reg <= '0;
            px_reg <= '0;
            py_reg <= '0;
            first_reg <= 1'b1;
        end else if (cmd.update) begin
            yaw_reg <= yaw_next;
            pitch_reg <= pitch_next;
            px_reg <= cx_reg;
            py_reg <= cy_reg;
            first_reg <= 1'b0;
        end
    end

    assign sts.cordic_done = cdone;
    assign forward_x = fx_reg;
    assign forward_y = fy_reg;
    assign forward_z = fz_reg;
    assign right_x = rx_reg;
    assign right_z = rz_reg;
    assign up_x = ux_reg;
    assign up_y = uy_reg;
    assign up_z = uz_reg;
    assign yaw_angle = yaw_out_reg;
    assign pitch_angle = pitch_out_reg;

    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (28'(pitch_reg) <= PITCH_LIM) && (28'(pitch_reg) >= -PITCH_LIM))
        else $error("pitch out of range");
    a_yaw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (28'(yaw_reg) < YAW_HALF) && (28'(yaw_reg) >= -YAW_HALF))
        else $error("yaw out of range");
    a_first_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |=> !first_reg) else $error("first flag not cleared");

endmodule

// ===== src/mlcb_ctrl.sv =====
// ============================================================================
// Mouse-look controller
// Sequences load, scaling, angle update, two CORDIC runs, products and output.
// ============================================================================
module mlcb_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output mlcb_pkg::mlcb_cmd_t cmd,
    input  mlcb_pkg::mlcb_sts_t sts
);
    import mlcb_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SCL  = 4'd1;
    localparam logic [3:0] ST_UPD  = 4'd2;
    localparam logic [3:0] ST_SYAW = 4'd3;
    localparam logic [3:0] ST_CYAW = 4'd4;
    localparam logic [3:0] ST_SPIT = 4'd5;
    localparam logic [3:0] ST_CPIT = 4'd6;
    localparam logic [3:0] ST_MUL  = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic mv_reg, mv_next;
    logic take;

    assign s_ready = (state_reg == ST_IDLE);
    assign take = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        idx_next = idx_reg;
        mv_next = mv_reg;
        cmd = '0;
        cmd.mul_idx = idx_reg;
        if (mv_reg && m_ready) mv_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    cmd.load = 1'b1;
                    state_next = ST_SCL;
                end
            end
            ST_SCL: begin
                cmd.scale = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                cmd.update = 1'b1;
                state_next = ST_SYAW;
            end
            ST_SYAW: begin
                cmd.cordic_sel = 1'b0;
                cmd.cordic_start = 1'b1;
                state_next = ST_CYAW;
            end
            ST_CYAW: begin
                cmd.cordic_sel = 1'b0;
                if (sts.cordic_done) state_next = ST_SPIT;
            end
            ST_SPIT: begin
                cmd.cordic_sel = 1'b1;
                cmd.cordic_start = 1'b1;
                state_next = ST_CPIT;
            end
            ST_CPIT: begin
                cmd.cordic_sel = 1'b1;
                if (sts.cordic_done) begin
                    state_next = ST_MUL;
                    idx_next = 2'd0;
                end
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!mv_reg || m_ready) begin
                    cmd.latch_out = 1'b1;
                    mv_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg <= mv_next;
        end
    end

    assign m_valid = mv_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && !m_ready) |=> mv_reg) else $error("result dropped");
    a_latch_safe: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.latch_out |-> (!mv_reg || m_ready)) else $error("result overwritten");
    a_idle_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> state_reg == ST_SCL) else $error("bad accept");

endmodule

// ===== src/mouse_look_camera_basis_top.sv =====
// ============================================================================
// Mouse-look camera basis top level
// Cursor samples in, camera forward, right and up vectors and angles out.
// ============================================================================
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    s_cursor_x, s_cursor_y
//  m_        out        m_valid/m_ready    vectors, m_yaw_angle, m_pitch_angle
//  APB       in         psel/penable       look_sensitivity at address 0
//
// Most of the work of a transaction is in the iterative CORDIC unit, which
// runs once for yaw and once for pitch. The result register holds a finished
// transaction while the next one is computed; the next result waits until the
// previous one is taken.
// Reset is synchronous and active low.
// ============================================================================
module mouse_look_camera_basis_top #(
    parameter int VECTOR_FRAC_BITS = 15,
    parameter int TRIG_ITERATIONS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [23:0] s_cursor_x,
    input  logic signed [23:0] s_cursor_y,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [15:0] m_forward_x,
    output logic signed [15:0] m_forward_y,
    output logic signed [15:0] m_forward_z,
    output logic signed [15:0] m_right_x,
    output logic signed [15:0] m_right_z,
    output logic signed [15:0] m_up_x,
    output logic signed [15:0] m_up_y,
    output logic signed [15:0] m_up_z,
    output logic signed [24:0] m_yaw_angle,
    output logic signed [23:0] m_pitch_angle
);
    import mlcb_pkg::*;

    logic [SENS_W-1:0] sens_reg;
    mlcb_cmd_t cmd;
    mlcb_sts_t sts;
    logic sel0;

    assign pready = 1'b1;
    assign sel0 = (paddr[2] == ADDR_SENS) && (paddr[1:0] == 2'b00);
    assign prdata = sel0 ? {16'd0, sens_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sens_reg <= 16'd6554;
        end else if (psel && penable && pwrite && sel0) begin
            sens_reg <= pwdata[SENS_W-1:0];
        end
    end

    mlcb_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .cmd(cmd), .sts(sts)
    );

    mlcb_datapath #(
        .VECTOR_FRAC_BITS(VECTOR_FRAC_BITS),
        .TRIG_ITERATIONS(TRIG_ITERATIONS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts), .sens(sens_reg),
        .cursor_x(s_cursor_x), .cursor_y(s_cursor_y),
        .forward_x(m_forward_x), .forward_y(m_forward_y), .forward_z(m_forward_z),
        .right_x(m_right_x), .right_z(m_right_z),
        .up_x(m_up_x), .up_y(m_up_y), .up_z(m_up_z),
        .yaw_angle(m_yaw_angle), .pitch_angle(m_pitch_angle)
    );

endmodule

// ===== verif/mouse_look_camera_basis_top_tb.sv =====
// ============================================================================
// Mouse-look camera basis testbench
// Drives cursor samples and sensitivity settings into the camera block and
// checks every vector and angle against a cycle-free fixed-point predictor.
// ============================================================================
module mouse_look_camera_basis_top_tb;

    import mlcb_pkg::*;

    localparam int VFRAC = 15;
    localparam int ITERS = 16;
    localparam longint SPAN = 23592960;
    localparam longint HALF = 11796480;
    localparam longint PLIM = 5832704;
    localparam longint D24 = 16777216;
    localparam int LIMIT = 2000000;

    typedef struct {
        logic signed [15:0] vec [8];
        logic signed [24:0] yaw;
        logic signed [23:0] pitch;
    } basis_t;

    class basis_scoreboard;
        basis_t pending[$];
        logic [15:0] sens;
        longint yaw_deg, pitch_deg, last_x, last_y;
        bit first;
        int errors;

        function void clear();
            sens = 16'd6554;
            yaw_deg = -90 * 65536;
            pitch_deg = 0;
            last_x = 0;
            last_y = 0;
            first = 1;
            errors = 0;
        endfunction

        function longint fshr(longint v, int k);
            return v >>> k;
        endfunction

        function longint rshr(longint v, int k);
            if (k == 0) return v;
            return (v + (longint'(1) << (k - 1))) >>> k;
        endfunction

        function void sincos(longint ang, output longint sn, output longint cs);
            longint z, x, y, dx, dy;
            bit flip;
            z = ang * 256;
            x = 652032874;
            y = 0;
            flip = 0;
            if (z > 90 * D24) begin
                z -= 180 * D24;
                flip = 1;
            end else if (z < -90 * D24) begin
                z += 180 * D24;
                flip = 1;
            end
            for (int i = 0; i < ITERS && i < 32; i++) begin
                dx = fshr(x, i);
                dy = fshr(y, i);
                if (z >= 0) begin
                    x -= dy;
                    y += dx;
                    z -= longint'(atan_deg24(i[4:0]));
                end else begin
                    x += dy;
                    y -= dx;
                    z += longint'(atan_deg24(i[4:0]));
                end
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            sn = y;
            cs = x;
        endfunction

        function logic signed [15:0] quant(longint v30);
            longint v;
            v = rshr(v30, 30 - VFRAC);
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return v[15:0];
        endfunction

        function void note_sample(logic signed [23:0] cx, logic signed [23:0] cy);
            longint dx, dy, t, sy, cyw, sp, cp;
            basis_t b;
            if (first) begin
                last_x = cx;
                last_y = cy;
                first = 0;
            end
            dx = rshr((longint'(cx) - last_x) * longint'(sens), 8);
            dy = rshr((last_y - longint'(cy)) * longint'(sens), 8);
            last_x = cx;
            last_y = cy;
            t = (yaw_deg + dx + HALF) % SPAN;
            if (t < 0) t += SPAN;
            yaw_deg = t - HALF;
            t = pitch_deg + dy;
            if (t > PLIM) t = PLIM;
            if (t < -PLIM) t = -PLIM;
            pitch_deg = t;
            sincos(yaw_deg, sy, cyw);
            sincos(pitch_deg, sp, cp);
            b.vec[0] = quant(rshr(cyw * cp, 30));
            b.vec[1] = quant(sp);
            b.vec[2] = quant(rshr(sy * cp, 30));
            b.vec[3] = quant(-sy);
            b.vec[4] = quant(cyw);
            b.vec[5] = quant(-rshr(cyw * sp, 30));
            b.vec[6] = quant(cp);
            b.vec[7] = quant(-rshr(sy * sp, 30));
            b.yaw = yaw_deg[24:0];
            b.pitch = pitch_deg[23:0];
            pending.push_back(b);
        endfunction

        function void check_basis(basis_t got);
            basis_t exp_b;
            bit bad;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result transaction");
                return;
            end
            exp_b = pending.pop_front();
            bad = (got.yaw !== exp_b.yaw) || (got.pitch !== exp_b.pitch);
            for (int i = 0; i < 8; i++)
                if (got.vec[i] !== exp_b.vec[i]) bad = 1;
            if (bad) begin
                errors++;
                if (errors <= 10) begin
                    $display("basis expected vec %p yaw %0d pitch %0d", exp_b.vec,
                             exp_b.yaw, exp_b.pitch);
                    $display("basis actual   vec %p yaw %0d pitch %0d", got.vec,
                             got.yaw, got.pitch);
                end
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 0;
    logic s_ready;
    logic signed [23:0] s_cursor_x = '0, s_cursor_y = '0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [15:0] m_forward_x, m_forward_y, m_forward_z, m_right_x, m_right_z;
    logic signed [15:0] m_up_x, m_up_y, m_up_z;
    logic signed [24:0] m_yaw_angle;
    logic signed [23:0] m_pitch_angle;

    basis_scoreboard sb;
    int cycles = 0;
    bit hold_off = 0;
    bit m_quiet = 0;
    logic signed [23:0] pos_x = 0, pos_y = 0;

    always #6 aclk = ~aclk;

    mouse_look_camera_basis_top i_dut (.*);

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("mouse_look_camera_basis_top: mismatch");
            $finish;
        end
    end

    always @(posedge aclk) begin
        basis_t got;
        if (aresetn && m_valid && m_ready) begin
            got.vec[0] = m_forward_x; got.vec[1] = m_forward_y;
            got.vec[2] = m_forward_z; got.vec[3] = m_right_x;
            got.vec[4] = m_right_z;   got.vec[5] = m_up_x;
            got.vec[6] = m_up_y;      got.vec[7] = m_up_z;
            got.yaw = m_yaw_angle;
            got.pitch = m_pitch_angle;
            sb.check_basis(got);
        end
    end

    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_ready <= 0;
            end else if (m_quiet) begin
                m_ready <= 1;
            end else if (m_ready && $urandom_range(0, 3) == 0) begin
                n = gap_len() + 1;
                m_ready <= 0;
                repeat (n) @(posedge aclk);
                m_ready <= 1;
            end else begin
                m_ready <= 1;
            end
        end
    end

    task automatic write_sens(logic [15:0] v);
        @(posedge aclk);
        psel <= 1; pwrite <= 1; paddr <= {ADDR_SENS, 2'b00}; pwdata <= {16'h0, v};
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.sens = v;
    endtask

    task automatic send_sample(logic signed [23:0] x, logic signed [23:0] y, bit gaps);
        if (gaps && $urandom_range(0, 2) == 0) begin
            repeat (gap_len()) @(posedge aclk);
        end
        s_valid <= 1;
        s_cursor_x <= x;
        s_cursor_y <= y;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(x, y);
        s_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic random_run(int count, bit gaps);
        int step;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 5))
                0: begin
                    pos_x = 24'($urandom);
                    pos_y = 24'($urandom);
                end
                1: begin
                    step = $urandom_range(0, 1) ? 8388607 : -8388608;
                    pos_x = pos_x + step[23:0];
                    pos_y = pos_y - step[23:0];
                end
                default: begin
                    step = $urandom_range(0, 20000);
                    pos_x = pos_x + step[23:0] - 24'sd10000;
                    step = $urandom_range(0, 20000);
                    pos_y = pos_y + step[23:0] - 24'sd10000;
                end
            endcase
            send_sample(pos_x, pos_y, gaps);
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        repeat (11) @(posedge aclk);
        aresetn <= 1;

        send_sample(24'sd1000, -24'sd1000, 0);
        send_sample(24'sd1000, -24'sd1000, 0);
        send_sample(24'sh7FFFFF, 24'sh800000, 0);
        send_sample(24'sh800000, 24'sh7FFFFF, 0);
        send_sample(24'sh7FFFFF, 24'sh7FFFFF, 0);
        send_sample(24'sd0, 24'sd0, 0);
        send_sample(24'sd230, -24'sd200, 0);
        send_sample(24'sd2600, 24'sd300, 0);
        send_sample(-24'sd5000, 24'sd9000, 0);
        send_sample(24'sh555555, -24'sh2AAAAA, 0);
        drain();
        write_sens(16'hFFFF);
        send_sample(24'sd0, 24'sd0, 0);
        send_sample(24'sd46080, -24'sd40000, 0);
        send_sample(24'sh800000, 24'sh7FFFFF, 0);
        send_sample(24'sd100, 24'sh800000, 0);
        drain();
        write_sens(16'h0000);
        send_sample(24'sh7FFFFF, 24'sh800000, 0);
        send_sample(-24'sd1, 24'sd1, 0);
        drain();
        write_sens(16'd6554);
        random_run(300, 1);

        hold_off = 1;
        fork
            random_run(6, 0);
            begin
                repeat (400) @(posedge aclk);
                hold_off = 0;
            end
        join
        drain();

        write_sens(16'($urandom));
        random_run(250, 1);
        drain();
        write_sens(16'd1);
        random_run(100, 1);
        drain();
        write_sens(16'hFFFF);
        random_run(150, 1);
        drain();
        write_sens(16'($urandom_range(100, 20000)));
        m_quiet = 1;
        random_run(150, 0);
        m_quiet = 0;
        random_run(50, 1);
        drain();

        if (sb.errors == 0) begin
            $display("mouse_look_camera_basis_top: match");
        end else begin
            $display("mouse_look_camera_basis_top: mismatch");
        end
        $finish;
    end

endmodule
